### hw/rtl/awbt_pkg.sv
// ----------------------------------------------------------------------------
// awbt_pkg
// shared types, byte classes and helper functions of the ascii word breaker
// ----------------------------------------------------------------------------
package awbt_pkg;

    localparam longint unsigned MAX_VALUE_LEN_DEF = 64'd65535;
    localparam int OFF_W = 16;
    localparam int CLASS_W = 3;

    typedef logic [CLASS_W-1:0] t_class;

    localparam t_class CL_BRK      = 3'd0;
    localparam t_class CL_LET      = 3'd1;
    localparam t_class CL_NUM      = 3'd2;
    localparam t_class CL_ENL      = 3'd3;
    localparam t_class CL_MID_LET  = 3'd4;
    localparam t_class CL_MID_NUM  = 3'd5;
    localparam t_class CL_MID_BOTH = 3'd6;

    localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;
    localparam logic [7:0] CH_COLON       = 8'h3A;
    localparam logic [7:0] CH_COMMA       = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON   = 8'h3B;
    localparam logic [7:0] CH_PERIOD      = 8'h2E;
    localparam logic [7:0] CH_APOSTROPHE  = 8'h27;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       last_of_value;
    } t_item;

    typedef struct packed {
        logic [OFF_W-1:0] token_start;
        logic [OFF_W-1:0] token_end;
        logic             last_of_run;
    } t_token;

    // up to two tokens per byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_token     first;
        t_token     second;
    } t_push;

    function automatic t_class byte_class(input logic [7:0] c);
        t_class k;
        k = CL_BRK;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            k = CL_LET;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = CL_NUM;
        end else if (c == CH_UNDERSCORE) begin
            k = CL_ENL;
        end else if (c == CH_COLON) begin
            k = CL_MID_LET;
        end else if (c == CH_COMMA || c == CH_SEMICOLON) begin
            k = CL_MID_NUM;
        end else if (c == CH_PERIOD || c == CH_APOSTROPHE) begin
            k = CL_MID_BOTH;
        end
        return k;
    endfunction

    function automatic logic is_word_class(input t_class k);
        return (k == CL_LET) || (k == CL_NUM) || (k == CL_ENL);
    endfunction

    function automatic logic is_mid_class(input t_class k);
        return (k == CL_MID_LET) || (k == CL_MID_NUM) || (k == CL_MID_BOTH);
    endfunction

    function automatic logic joins(input t_class mid, input t_class prev, input t_class nxt);
        logic j;
        case (mid)
            CL_MID_BOTH: j = (prev == nxt) && ((prev == CL_LET) || (prev == CL_NUM));
            CL_MID_LET:  j = (prev == CL_LET) && (nxt == CL_LET);
            CL_MID_NUM:  j = (prev == CL_NUM) && (nxt == CL_NUM);
            default:     j = 1'b0;
        endcase
        return j;
    endfunction

endpackage

### hw/rtl/awbt_byte_if.sv
// ----------------------------------------------------------------------------
// awbt_byte_if
// byte channel into the word breaker
// ----------------------------------------------------------------------------
interface awbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       last_of_value;

    modport source (output valid, output value_byte, output last_of_value, input ready);
    modport sink   (input valid, input value_byte, input last_of_value, output ready);
endinterface

### hw/rtl/awbt_token_if.sv
// ----------------------------------------------------------------------------
// awbt_token_if
// token offset channel out of the word breaker
// ----------------------------------------------------------------------------
interface awbt_token_if;
    logic        valid;
    logic        ready;
    logic [15:0] token_start;
    logic [15:0] token_end;
    logic        last_of_run;

    modport source (output valid, output token_start, output token_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_start, input token_end,
                    input last_of_run, output ready);
endinterface

### hw/rtl/awbt_in_reg.sv
// ----------------------------------------------------------------------------
// awbt_in_reg
// input register, refilled in the same cycle the core takes its byte
// ----------------------------------------------------------------------------
module awbt_in_reg
    import awbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### hw/rtl/awbt_core.sv
// ----------------------------------------------------------------------------
// awbt_core
// word state update for one byte and up to two closed words
// ----------------------------------------------------------------------------
module awbt_core
    import awbt_pkg::*;
#(
    parameter longint unsigned MAX_VALUE_LEN = MAX_VALUE_LEN_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    output t_push o_push
);

    localparam int POS_W = $clog2(MAX_VALUE_LEN + 64'd1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_VALUE_LEN);

    function automatic logic [OFF_W-1:0] to_off(input logic [POS_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OFF_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_W'(1);
    endfunction

    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_in_word, n_in_word;
    logic [POS_W-1:0] r_start, n_start;
    logic             r_seen,  n_seen;
    t_class           r_lwc,   n_lwc;
    logic             r_mid,   n_mid;
    t_class           r_pmc,   n_pmc;
    logic [POS_W-1:0] r_mid_off, n_mid_off;

    t_class           k;
    logic             emit_a, emit_b;
    t_token           tok_a, tok_b;
    logic [POS_W-1:0] end_b;

    always_comb begin
        k         = byte_class(i_item.value_byte);
        n_pos     = r_pos;
        n_in_word = r_in_word;
        n_start   = r_start;
        n_seen    = r_seen;
        n_lwc     = r_lwc;
        n_mid     = r_mid;
        n_pmc     = r_pmc;
        n_mid_off = r_mid_off;
        emit_a    = 1'b0;
        emit_b    = 1'b0;
        tok_a     = '0;
        tok_b     = '0;
        end_b     = '0;

        // word state for the byte itself
        if (r_in_word) begin
            if (r_mid) begin
                if (is_word_class(k) && joins(r_pmc, r_lwc, k)) begin
                    n_mid = 1'b0;
                    n_pmc = CL_BRK;
                    n_lwc = k;
                end else begin
                    emit_a            = r_seen;
                    tok_a.token_start = to_off(r_start);
                    tok_a.token_end   = to_off(r_mid_off);
                    n_in_word         = 1'b0;
                    n_mid             = 1'b0;
                    n_pmc             = CL_BRK;
                    n_lwc             = CL_BRK;
                    n_seen            = 1'b0;
                    if (is_word_class(k)) begin
                        n_in_word = 1'b1;
                        n_start   = r_pos;
                        n_seen    = (k == CL_LET) || (k == CL_NUM);
                        n_lwc     = k;
                    end
                end
            end else if (is_word_class(k)) begin
                n_lwc  = k;
                n_seen = r_seen || (k == CL_LET) || (k == CL_NUM);
            end else if (is_mid_class(k)) begin
                n_mid     = 1'b1;
                n_pmc     = k;
                n_mid_off = r_pos;
            end else begin
                emit_a            = r_seen;
                tok_a.token_start = to_off(r_start);
                tok_a.token_end   = to_off(r_pos);
                n_in_word         = 1'b0;
                n_mid             = 1'b0;
                n_pmc             = CL_BRK;
                n_lwc             = CL_BRK;
                n_seen            = 1'b0;
            end
        end else if (is_word_class(k)) begin
            n_in_word = 1'b1;
            n_start   = r_pos;
            n_seen    = (k == CL_LET) || (k == CL_NUM);
            n_lwc     = k;
            n_mid     = 1'b0;
            n_pmc     = CL_BRK;
        end

        // end of value flushes the open word and restarts offsets
        if (i_item.last_of_value) begin
            end_b             = n_mid ? n_mid_off : sat_inc(r_pos);
            emit_b            = n_in_word && n_seen;
            tok_b.token_start = to_off(n_start);
            tok_b.token_end   = to_off(end_b);
            n_pos             = '0;
            n_in_word         = 1'b0;
            n_start           = '0;
            n_seen            = 1'b0;
            n_lwc             = CL_BRK;
            n_mid             = 1'b0;
            n_pmc             = CL_BRK;
            n_mid_off         = '0;
        end else begin
            n_pos = sat_inc(r_pos);
        end

        tok_a.last_of_run = !emit_b;
        tok_b.last_of_run = 1'b1;

        o_push = '0;
        if (i_take) begin
            if (emit_a && emit_b) begin
                o_push.cnt    = 2'd2;
                o_push.first  = tok_a;
                o_push.second = tok_b;
            end else if (emit_a) begin
                o_push.cnt   = 2'd1;
                o_push.first = tok_a;
            end else if (emit_b) begin
                o_push.cnt   = 2'd1;
                o_push.first = tok_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_in_word <= 1'b0;
            r_start   <= '0;
            r_seen    <= 1'b0;
            r_lwc     <= CL_BRK;
            r_mid     <= 1'b0;
            r_pmc     <= CL_BRK;
            r_mid_off <= '0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_in_word <= n_in_word;
            r_start   <= n_start;
            r_seen    <= n_seen;
            r_lwc     <= n_lwc;
            r_mid     <= n_mid;
            r_pmc     <= n_pmc;
            r_mid_off <= n_mid_off;
        end
    end

endmodule

### hw/rtl/awbt_out_fifo.sv
// ----------------------------------------------------------------------------
// awbt_out_fifo
// four-entry token queue, takes up to two tokens and sends one per transfer
// ----------------------------------------------------------------------------
module awbt_out_fifo
    import awbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_token           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             pop;

    assign o_room  = (r_cnt <= (PTR_W+1)'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.cnt);
        n_rd  = pop ? r_rd + PTR_W'(1) : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(i_push.cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

### hw/rtl/ascii_word_break_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// ascii_word_break_tokenizer_unit
// ascii word breaker: byte stream in, word start and end offsets out
// ----------------------------------------------------------------------------
// i_byte carries one byte of a text value per transfer, last_of_value set on
// its final byte. o_token carries one word per transfer: the offset of its
// first byte, the offset just past its last byte, and last_of_run on the
// last word caused by one input byte (one byte may close up to two words).
// A new byte is taken every cycle while the queue has room for two words. A
// word is offered once the byte that closes it has passed the input register,
// where the class lookup and word state update run on it, and the word has
// been written into a four-entry queue. The core takes a byte only while the
// queue has room for two words, so a stalled receiver holds back i_byte after
// the queue fills and no word is lost. Offsets saturate at MAX_VALUE_LEN and
// are sent in their low 16 bits. Reset clears the word state, restarts offsets
// at zero and empties the queue.
// ----------------------------------------------------------------------------
module ascii_word_break_tokenizer_unit
    import awbt_pkg::*;
#(
    parameter longint unsigned MAX_VALUE_LEN = MAX_VALUE_LEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    awbt_byte_if.sink    i_byte,
    awbt_token_if.source o_token
);

    t_item  in_item;
    t_item  core_item;
    logic   core_valid;
    logic   core_take;
    logic   room;
    t_push  push;
    t_token head;

    assign in_item.value_byte    = i_byte.value_byte;
    assign in_item.last_of_value = i_byte.last_of_value;
    assign core_take             = core_valid && room;

    awbt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .o_ready (i_byte.ready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .o_item  (core_item),
        .i_take  (core_take)
    );

    awbt_core #(
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (core_take),
        .i_item  (core_item),
        .o_push  (push)
    );

    awbt_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_token.valid),
        .i_ready (o_token.ready),
        .o_token (head)
    );

    assign o_token.token_start = head.token_start;
    assign o_token.token_end   = head.token_end;
    assign o_token.last_of_run = head.last_of_run;

endmodule

### tb/ascii_word_break_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// ascii_word_break_tokenizer_unit_tb
// Drives text values byte by byte into the word breaker and checks every
// token against hand-written offsets or a cycle-free model of the ascii
// word rules kept in this bench. A short table of hand-picked bytes comes
// first, then random values built from runs of letters and digits glued
// by joiners, breaks and stray bytes. Both channels stall at random, and the
// token side holds off once for a long stretch so the byte side backs up.
// ----------------------------------------------------------------------------
module ascii_word_break_tokenizer_unit_tb;
    import awbt_pkg::*;

    localparam int          GAP_PCT      = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          BY_MODEL     = -1;
    localparam int unsigned MAX_LEN      = 32'(MAX_VALUE_LEN_DEF);

    typedef enum {K_LETTER, K_DIGIT, K_UNDERSCORE, K_JOINER, K_BREAK, K_ANY} t_char_kind;

    typedef logic [7:0] t_text [$];

    typedef struct {
        logic [7:0]  b;
        logic        last;
        int          n;
        logic [15:0] s0;
        logic [15:0] e0;
        logic [15:0] s1;
        logic [15:0] e1;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    awbt_byte_if  byte_ch ();
    awbt_token_if tok_ch ();

    ascii_word_break_tokenizer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_token (tok_ch)
    );

    // word tracking state
    int unsigned pos;
    logic        word_open;
    int unsigned word_from;
    logic        word_has_alnum;
    t_class      tail_class;
    logic        joiner_held;
    t_class      joiner_class;
    int unsigned joiner_at;
    t_token      word_out [2];
    int          word_n;

    t_token due_tokens [$];
    t_row   offered_rows [$];
    t_row   directed_rows [$];

    int   fail_count;
    int   words_checked;
    int   bytes_taken;
    int   values_done;
    int   bytes_offered;
    int   quiet;
    logic no_gaps;
    logic hold_req;

    function automatic void clear_words();
        pos            = 0;
        word_open      = 1'b0;
        word_from      = 0;
        word_has_alnum = 1'b0;
        tail_class     = CL_BRK;
        joiner_held    = 1'b0;
        joiner_class   = CL_BRK;
        joiner_at      = 0;
    endfunction

    function automatic int unsigned bump(input int unsigned p);
        return (p >= MAX_LEN) ? MAX_LEN : p + 1;
    endfunction

    function automatic logic forms_word(input t_class k);
        return (k == CL_LET) || (k == CL_NUM) || (k == CL_ENL);
    endfunction

    function automatic void open_word(input int unsigned p, input t_class k);
        word_open      = 1'b1;
        word_from      = p;
        word_has_alnum = (k == CL_LET) || (k == CL_NUM);
        tail_class     = k;
        joiner_held    = 1'b0;
        joiner_class   = CL_BRK;
    endfunction

    function automatic void close_word(input int unsigned stop);
        word_open    = 1'b0;
        joiner_held  = 1'b0;
        joiner_class = CL_BRK;
        tail_class   = CL_BRK;
        if (word_has_alnum && word_n < 2) begin
            word_has_alnum = 1'b0;
            word_out[word_n].token_start = word_from[15:0];
            word_out[word_n].token_end   = stop[15:0];
            word_out[word_n].last_of_run = 1'b0;
            word_n++;
        end
    endfunction

    function automatic void break_words(input logic [7:0] b, input logic last);
        t_class      k;
        int unsigned p;
        logic        pair_ok;
        k = CL_BRK;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
            k = CL_LET;
        end else if (b >= "0" && b <= "9") begin
            k = CL_NUM;
        end else if (b == CH_UNDERSCORE) begin
            k = CL_ENL;
        end else if (b == CH_COLON) begin
            k = CL_MID_LET;
        end else if (b == CH_COMMA || b == CH_SEMICOLON) begin
            k = CL_MID_NUM;
        end else if (b == CH_PERIOD || b == CH_APOSTROPHE) begin
            k = CL_MID_BOTH;
        end
        p      = pos;
        word_n = 0;
        if (word_open) begin
            if (joiner_held) begin
                pair_ok = (k == tail_class) && (k == CL_LET || k == CL_NUM);
                case (joiner_class)
                    CL_MID_LET:  pair_ok = pair_ok && (k == CL_LET);
                    CL_MID_NUM:  pair_ok = pair_ok && (k == CL_NUM);
                    CL_MID_BOTH: pair_ok = pair_ok;
                    default:     pair_ok = 1'b0;
                endcase
                if (pair_ok) begin
                    joiner_held  = 1'b0;
                    joiner_class = CL_BRK;
                    tail_class   = k;
                end else begin
                    close_word(joiner_at);
                    if (forms_word(k)) begin
                        open_word(p, k);
                    end
                end
            end else if (forms_word(k)) begin
                tail_class = k;
                if (k == CL_LET || k == CL_NUM) begin
                    word_has_alnum = 1'b1;
                end
            end else if (k == CL_MID_LET || k == CL_MID_NUM || k == CL_MID_BOTH) begin
                joiner_held  = 1'b1;
                joiner_class = k;
                joiner_at    = p;
            end else begin
                close_word(p);
            end
        end else if (forms_word(k)) begin
            open_word(p, k);
        end
        if (last) begin
            if (word_open) begin
                close_word(joiner_held ? joiner_at : bump(p));
            end
            clear_words();
        end else begin
            pos = bump(p);
        end
        if (word_n > 0) begin
            word_out[word_n-1].last_of_run = 1'b1;
        end
    endfunction

    function automatic t_row row(input logic [7:0] b, input logic last, input int n,
                                 input logic [15:0] s0 = 0, input logic [15:0] e0 = 0,
                                 input logic [15:0] s1 = 0, input logic [15:0] e1 = 0);
        t_row r;
        r.b    = b;
        r.last = last;
        r.n    = n;
        r.s0   = s0;
        r.e0   = e0;
        r.s1   = s1;
        r.e1   = e1;
        return r;
    endfunction

    function automatic logic [7:0] pick_char(input t_char_kind kind);
        logic [7:0] c;
        case (kind)
            K_LETTER:     c = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
            K_DIGIT:      c = 8'h30 + 8'($urandom_range(0, 9));
            K_UNDERSCORE: c = CH_UNDERSCORE;
            K_JOINER: begin
                case ($urandom_range(0, 4))
                    0:       c = CH_COLON;
                    1:       c = CH_COMMA;
                    2:       c = CH_SEMICOLON;
                    3:       c = CH_PERIOD;
                    default: c = CH_APOSTROPHE;
                endcase
            end
            K_BREAK:      c = $urandom_range(0, 1) ? 8'h20 : 8'h2D;
            default:      c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_sep();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) begin
            return pick_char(K_JOINER);
        end else if (r < 14) begin
            return pick_char(K_BREAK);
        end else if (r < 16) begin
            return pick_char(K_UNDERSCORE);
        end else begin
            return pick_char(K_ANY);
        end
    endfunction

    // optional leading separator, then runs of letters or digits, each followed by one separator byte, cut to len
    function automatic t_text make_text(input int len);
        t_text      t;
        t_char_kind kind;
        if ($urandom_range(0, 4) == 0) begin
            t.push_back(pick_sep());
        end
        while (t.size() < len) begin
            kind = $urandom_range(0, 2) ? K_LETTER : K_DIGIT;
            repeat ($urandom_range(1, 4)) t.push_back(pick_char(kind));
            t.push_back(pick_sep());
        end
        while (t.size() > len) begin
            void'(t.pop_back());
        end
        return t;
    endfunction

    task automatic offer_byte(input t_row r);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        offered_rows.push_back(r);
        byte_ch.valid         <= 1'b1;
        byte_ch.value_byte    <= r.b;
        byte_ch.last_of_value <= r.last;
        bytes_offered++;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_text(input t_text t);
        foreach (t[i]) begin
            offer_byte(row(t[i], i == t.size() - 1, BY_MODEL));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // token side: random stalls, one long hold-off on request
    initial begin
        tok_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                tok_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                tok_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_row   r;
        t_token got;
        t_token want;
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            got.token_start = tok_ch.token_start;
            got.token_end   = tok_ch.token_end;
            got.last_of_run = tok_ch.last_of_run;
            if (due_tokens.size() == 0) begin
                $error("token %0d..%0d with none expected", got.token_start, got.token_end);
                fail_count++;
            end else begin
                want = due_tokens.pop_front();
                if (got.token_start !== want.token_start) begin
                    $error("token_start: expected %0d, got %0d",
                           want.token_start, got.token_start);
                    fail_count++;
                end
                if (got.token_end !== want.token_end) begin
                    $error("token_end: expected %0d, got %0d", want.token_end, got.token_end);
                    fail_count++;
                end
                if (got.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, got.last_of_run);
                    fail_count++;
                end
                words_checked++;
            end
        end
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            r = offered_rows.pop_front();
            break_words(byte_ch.value_byte, byte_ch.last_of_value);
            if (r.n == BY_MODEL) begin
                for (int i = 0; i < word_n; i++) begin
                    due_tokens.push_back(word_out[i]);
                end
            end else begin
                for (int i = 0; i < r.n; i++) begin
                    want.token_start = (i == 0) ? r.s0 : r.s1;
                    want.token_end   = (i == 0) ? r.e0 : r.e1;
                    want.last_of_run = (i == r.n - 1);
                    due_tokens.push_back(want);
                end
            end
            bytes_taken++;
            if (byte_ch.last_of_value) begin
                values_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int    first_random;
        int    len;
        fail_count    = 0;
        words_checked = 0;
        bytes_taken   = 0;
        values_done   = 0;
        bytes_offered = 0;
        quiet         = 0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        clear_words();
        i_rst_n               <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.value_byte    <= 8'h00;
        byte_ch.last_of_value <= 1'b0;

        // single letter straight after reset
        directed_rows.push_back(row("A", 1'b1, 1, 0, 1));
        // joined digits, joiner after underscore, high byte as break
        directed_rows.push_back(row("z", 1'b0, BY_MODEL));
        directed_rows.push_back(row("9", 1'b0, BY_MODEL));
        directed_rows.push_back(row(CH_PERIOD, 1'b0, BY_MODEL));
        directed_rows.push_back(row("0", 1'b0, BY_MODEL));
        directed_rows.push_back(row(" ", 1'b0, BY_MODEL));
        directed_rows.push_back(row(CH_UNDERSCORE, 1'b0, BY_MODEL));
        directed_rows.push_back(row(CH_COLON, 1'b0, 0));
        directed_rows.push_back(row("a", 1'b0, 0));
        directed_rows.push_back(row(8'hFF, 1'b1, 1, 7, 8));
        // two joiners in a row
        directed_rows.push_back(row("5", 1'b0, 0));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0));
        directed_rows.push_back(row(CH_PERIOD, 1'b0, 1, 0, 1));
        directed_rows.push_back(row("7", 1'b1, BY_MODEL));
        // failed joiner and a closing word on the same byte
        directed_rows.push_back(row("a", 1'b0, 0));
        directed_rows.push_back(row(CH_COLON, 1'b0, 0));
        directed_rows.push_back(row("3", 1'b1, 2, 0, 1, 2, 3));
        // joiner on the final byte
        directed_rows.push_back(row("b", 1'b0, 0));
        directed_rows.push_back(row("c", 1'b0, 0));
        directed_rows.push_back(row(CH_APOSTROPHE, 1'b1, 1, 0, 2));
        // digit comma digit, then underscore and lowest high byte
        directed_rows.push_back(row("1", 1'b0, 0));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0));
        directed_rows.push_back(row("2", 1'b0, 0));
        directed_rows.push_back(row(CH_UNDERSCORE, 1'b0, 0));
        directed_rows.push_back(row(8'h80, 1'b1, 1, 0, 4));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_byte(directed_rows[i]);
        end

        hold_req     = 1'b1;
        first_random = bytes_offered;
        while (bytes_offered - first_random < RANDOM_ITEMS) begin
            no_gaps = (bytes_offered - first_random >= 400) &&
                      (bytes_offered - first_random < 700);
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            send_text(make_text(len));
        end
        no_gaps = 1'b0;
        byte_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (due_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        foreach (due_tokens[i]) begin
            $error("token %0d..%0d never arrived",
                   due_tokens[i].token_start, due_tokens[i].token_end);
            fail_count++;
        end

        $display("bytes transferred: %0d in %0d values, words checked: %0d",
                 bytes_taken, values_done, words_checked);
        $display("random values with a %0d cycle receiver hold-off and a run with no idling",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
